FILE: rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  // Storage shape of the queue.
  localparam int CAPACITY   = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int HALF_CAP   = CAPACITY / 2;

  // Fixed widths of the port fields.
  localparam int MODE_W     = 3;
  localparam int IN_DATA_W  = 32;
  localparam int IDX_W      = 11;
  localparam int OUT_DATA_W = 32;
  localparam int STATUS_W   = 2;
  localparam int OUT_LEN_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK       = 3'd4,
    MODE_RESIZE     = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Control broadcast to every cell of the ring.
  typedef struct packed {
    logic              rot_left;
    logic              rot_right;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
  } chain_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bdq_cell.sv
`default_nettype none

module bdq_cell import bdq_pkg::*; (
  input  logic                  clk,
  input  logic [SLOT_W-1:0]     cell_idx,
  input  chain_ctl_t            ctl,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  // A rotation moves every word one place; otherwise the addressed cell takes the write.
  always_comb begin
    word_nxt = word_r;
    if (ctl.rot_left) begin
      word_nxt = right_word;
    end else if (ctl.rot_right) begin
      word_nxt = left_word;
    end else if (ctl.wr_en && (ctl.wr_slot == cell_idx)) begin
      word_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

FILE: rtl/bdq_chain.sv
`default_nettype none

module bdq_chain import bdq_pkg::*; (
  input  logic                  clk,
  input  chain_ctl_t            ctl,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] head_word
);

  logic [DATA_WIDTH-1:0] words [CAPACITY];

  // The cells close into a ring: the last cell neighbors the first.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i + CAPACITY - 1) % CAPACITY;
    localparam int RIGHT = (i + 1) % CAPACITY;

    bdq_cell u_cell (
      .clk        (clk),
      .cell_idx   (SLOT_W'(i)),
      .ctl        (ctl),
      .wr_data    (wr_data),
      .left_word  (words[LEFT]),
      .right_word (words[RIGHT]),
      .word       (words[i])
    );
  end

  assign head_word = words[0];

endmodule

`default_nettype wire

FILE: rtl/bounded_deque_engine.sv
`default_nettype none

// Bounded double-ended queue of up to CAPACITY data words, kept in a ring of identical
// storage cells. Each input beat carries one request (push front or back, pop front or
// back, peek at a position counted from the front, resize, clear) and yields exactly one
// result beat with the peeked word, a status code and the queue length after the request.
// The block works on one request at a time. A push, pop, clear, shrinking resize, failed
// request or out-of-range peek is finished in the execute state. A resize that grows the
// queue writes one fill word per cycle through the single broadcast write of the ring
// until the new length is reached. A peek in range rotates the whole ring one place per
// cycle, in the shorter direction, until the wanted entry sits in cell zero, the only
// read point, where it is read out. The rotation is not undone, the front pointer simply
// follows it. A finished result sits in an output register, and if that register is
// still occupied the block holds the result until it drains. The storage has no reset;
// only entries that were written are ever read.

module bounded_deque_engine import bdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [IN_DATA_W-1:0]  in_data_in,
  input  logic [IDX_W-1:0]      in_index,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_DATA_W-1:0] out_data_out,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_LEN_W-1:0]  out_length
);

  // Sequencer states: accept, decode and execute, grow fill loop, peek rotation,
  // and waiting for the output register to free up.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_GROW = 5'b00100,
    S_SEEK = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  logic [MODE_W-1:0]     mode_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [IDX_W-1:0]      idx_r;

  // Queue bookkeeping: ring slot of the front entry, and the entry count.
  logic [SLOT_W-1:0]     front_r, front_nxt;
  logic [LEN_W-1:0]      count_r, count_nxt;

  // A result that could not enter the output register yet.
  logic [DATA_WIDTH-1:0] hold_data_r;
  status_t               hold_status_r;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  status_t               out_status_r;
  logic [OUT_LEN_W-1:0]  out_length_r;

  // Result of the current cycle's work.
  logic                  finish;
  logic [DATA_WIDTH-1:0] res_data;
  status_t               res_status;
  logic                  out_free;
  logic                  out_load;

  chain_ctl_t            ctl;
  logic [DATA_WIDTH-1:0] head_word;
  logic [SLOT_W-1:0]     seek_slot;
  logic [SLOT_W-1:0]     back_slot;

  // (base + off) modulo CAPACITY; correct while off does not exceed CAPACITY, as wherever the result is used.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [LEN_W-1:0]  off);
    logic [LEN_W:0] sum;
    sum = (LEN_W + 1)'(base) + (LEN_W + 1)'(off);
    if (sum >= (LEN_W + 1)'(CAPACITY)) begin
      sum = sum - (LEN_W + 1)'(CAPACITY);
    end
    return SLOT_W'(sum);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(CAPACITY - 1) : SLOT_W'(s - 1'b1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(CAPACITY - 1)) ? '0 : SLOT_W'(s + 1'b1);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Slot just past the back entry, and the slot holding the peeked entry.
  assign back_slot = slot_add(front_r, count_r);
  assign seek_slot = slot_add(front_r, LEN_W'(idx_r));

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    finish      = 1'b0;
    res_data    = '0;
    res_status  = ST_OK;
    ctl         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_r)
          MODE_PUSH_FRONT: begin
            finish = 1'b1;
            if (32'(count_r) >= CAPACITY) begin
              res_status = ST_FULL;
            end else begin
              front_nxt   = slot_dec(front_r);
              ctl.wr_en   = 1'b1;
              ctl.wr_slot = slot_dec(front_r);
              count_nxt   = LEN_W'(count_r + 1'b1);
            end
          end
          MODE_PUSH_BACK: begin
            finish = 1'b1;
            if (32'(count_r) >= CAPACITY) begin
              res_status = ST_FULL;
            end else begin
              ctl.wr_en   = 1'b1;
              ctl.wr_slot = back_slot;
              count_nxt   = LEN_W'(count_r + 1'b1);
            end
          end
          MODE_POP_FRONT: begin
            finish = 1'b1;
            if (count_r == '0) begin
              res_status = ST_EMPTY;
            end else begin
              front_nxt = slot_inc(front_r);
              count_nxt = LEN_W'(count_r - 1'b1);
            end
          end
          MODE_POP_BACK: begin
            finish = 1'b1;
            if (count_r == '0) begin
              res_status = ST_EMPTY;
            end else begin
              count_nxt = LEN_W'(count_r - 1'b1);
            end
          end
          MODE_PEEK: begin
            if (32'(idx_r) >= 32'(count_r)) begin
              finish     = 1'b1;
              res_status = ST_RANGE;
            end else begin
              state_nxt = S_SEEK;
            end
          end
          MODE_RESIZE: begin
            if (32'(idx_r) > CAPACITY) begin
              finish     = 1'b1;
              res_status = ST_FULL;
            end else if (32'(count_r) < 32'(idx_r)) begin
              state_nxt = S_GROW;
            end else begin
              finish    = 1'b1;
              count_nxt = LEN_W'(idx_r);
            end
          end
          MODE_CLEAR: begin
            finish = 1'b1;
            if (count_r == '0) begin
              res_status = ST_EMPTY;
            end else begin
              count_nxt = '0;
              front_nxt = '0;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      // One fill word per cycle at the back; entered only with count below the target.
      S_GROW: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_slot = back_slot;
        count_nxt   = LEN_W'(count_r + 1'b1);
        if (32'(count_nxt) == 32'(idx_r)) begin
          finish = 1'b1;
        end
      end

      // Turn the ring until the wanted entry reaches cell zero. Turning left moves
      // every word one cell down, so the front slot moves down with it.
      S_SEEK: begin
        if (seek_slot == '0) begin
          finish   = 1'b1;
          res_data = head_word;
        end else if (32'(seek_slot) <= HALF_CAP) begin
          ctl.rot_left = 1'b1;
          front_nxt    = slot_dec(front_r);
        end else begin
          ctl.rot_right = 1'b1;
          front_nxt     = slot_inc(front_r);
        end
      end

      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign out_load = (finish || (state_r == S_HOLD)) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      mode_r <= in_mode;
      data_r <= DATA_WIDTH'(in_data_in);
      idx_r  <= in_index;
    end
    if (finish && !out_free) begin
      hold_data_r   <= res_data;
      hold_status_r <= res_status;
    end
    if (out_load) begin
      if (finish) begin
        out_data_r   <= OUT_DATA_W'(res_data);
        out_status_r <= res_status;
        out_length_r <= OUT_LEN_W'(count_nxt);
      end else begin
        out_data_r   <= OUT_DATA_W'(hold_data_r);
        out_status_r <= hold_status_r;
        out_length_r <= OUT_LEN_W'(count_r);
      end
    end
  end

  bdq_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .wr_data   (data_r),
    .head_word (head_word)
  );

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_length   = out_length_r;

  // The entry count never goes past the ring size.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("entry count exceeds capacity");

  // The ring either turns or takes a write in a cycle, never both.
  a_rot_xor_write : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_en && (ctl.rot_left || ctl.rot_right)) && !(ctl.rot_left && ctl.rot_right))
    else $error("ring rotation collides with a write");

  // A peek only turns the ring when there is an entry to find.
  a_seek_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEEK) |-> (count_r != '0))
    else $error("peek rotation on an empty queue");

  // An accepted beat is decoded in the very next cycle.
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted request was not executed");

endmodule

`default_nettype wire

FILE: test/tb_bounded_deque_engine.sv
`timescale 1ns / 100ps

module tb_bounded_deque_engine;
  import bdq_pkg::*;

  // The spare mode code has no member in mode_t; the block must treat it as a no-op.
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

  // Shapes of the random traffic: balanced, growing toward full, draining toward empty.
  localparam int PH_MIXED = 0;
  localparam int PH_GROW  = 1;
  localparam int PH_DRAIN = 2;

  localparam int RANDOM_ITEMS = 1550;
  localparam int MAX_GAP      = 11;
  // Cycles the receiver refuses results once, so the engine backs up into its input.
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_BEAT = 400;
  // The slowest legal pause between beats is a full-depth growing resize or the long
  // hold above, so this limit leaves a wide margin.
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] data;
    status_t               status;
    logic [OUT_LEN_W-1:0]  length;
  } deque_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [IN_DATA_W-1:0]  data;
    logic [IDX_W-1:0]      index;
    logic                  typed;
    deque_result_t         known;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [IN_DATA_W-1:0]  in_data_in = '0;
  logic [IDX_W-1:0]      in_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_DATA_W-1:0] out_data_out;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_LEN_W-1:0]  out_length;

  // Shadow copy of the queue, advanced once per accepted request.
  logic [DATA_WIDTH-1:0] shadow_mem [CAPACITY];
  int                    shadow_head;
  int                    shadow_count;

  deque_result_t pending_results [$];
  int            fault_count;
  int            quiet_cycles;

  // Directed rows. Where the outcome is obvious (errors, extremes, lengths after
  // reset) it is written out; the remaining rows lean on the shadow model.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_POP_FRONT,  32'h0,        11'd0,    1'b1, '{32'h0,        ST_EMPTY, 11'd0}},
    '{MODE_POP_BACK,   32'h0,        11'd0,    1'b1, '{32'h0,        ST_EMPTY, 11'd0}},
    '{MODE_CLEAR,      32'h0,        11'd0,    1'b1, '{32'h0,        ST_EMPTY, 11'd0}},
    '{MODE_PEEK,       32'h0,        11'd0,    1'b1, '{32'h0,        ST_RANGE, 11'd0}},
    '{MODE_SPARE,      32'hFFFFFFFF, 11'd2047, 1'b1, '{32'h0,        ST_OK,    11'd0}},
    '{MODE_PUSH_BACK,  32'hFFFFFFFF, 11'd0,    1'b1, '{32'h0,        ST_OK,    11'd1}},
    '{MODE_PUSH_FRONT, 32'h00000000, 11'd0,    1'b1, '{32'h0,        ST_OK,    11'd2}},
    '{MODE_PUSH_FRONT, 32'hA5A5A5A5, 11'd0,    1'b1, '{32'h0,        ST_OK,    11'd3}},
    '{MODE_PEEK,       32'h0,        11'd0,    1'b1, '{32'hA5A5A5A5, ST_OK,    11'd3}},
    '{MODE_PEEK,       32'h0,        11'd2,    1'b1, '{32'hFFFFFFFF, ST_OK,    11'd3}},
    '{MODE_PEEK,       32'h0,        11'd3,    1'b1, '{32'h0,        ST_RANGE, 11'd3}},
    '{MODE_PEEK,       32'h0,        11'd2047, 1'b1, '{32'h0,        ST_RANGE, 11'd3}},
    '{MODE_RESIZE,     32'h11111111, 11'd1025, 1'b1, '{32'h0,        ST_FULL,  11'd3}},
    '{MODE_RESIZE,     32'h5A5A5A5A, 11'd1024, 1'b1, '{32'h0,        ST_OK,    11'd1024}},
    '{MODE_PUSH_BACK,  32'h22222222, 11'd0,    1'b1, '{32'h0,        ST_FULL,  11'd1024}},
    '{MODE_PUSH_FRONT, 32'h33333333, 11'd0,    1'b1, '{32'h0,        ST_FULL,  11'd1024}},
    '{MODE_PEEK,       32'h0,        11'd1023, 1'b1, '{32'h5A5A5A5A, ST_OK,    11'd1024}},
    '{MODE_POP_FRONT,  32'h0,        11'd0,    1'b1, '{32'h0,        ST_OK,    11'd1023}},
    '{MODE_POP_BACK,   32'h0,        11'd0,    1'b1, '{32'h0,        ST_OK,    11'd1022}},
    '{MODE_RESIZE,     32'h0,        11'd5,    1'b1, '{32'h0,        ST_OK,    11'd5}},
    '{MODE_PEEK,       32'h0,        11'd4,    1'b0, '{32'h0,        ST_OK,    11'd0}},
    '{MODE_RESIZE,     32'h0F0F0F0F, 11'd9,    1'b0, '{32'h0,        ST_OK,    11'd0}},
    '{MODE_PEEK,       32'h0,        11'd8,    1'b0, '{32'h0,        ST_OK,    11'd0}},
    '{MODE_CLEAR,      32'h0,        11'd0,    1'b1, '{32'h0,        ST_OK,    11'd0}},
    '{MODE_RESIZE,     32'h44444444, 11'd0,    1'b1, '{32'h0,        ST_OK,    11'd0}}
  };

  bounded_deque_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_in   (in_data_in),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_length   (out_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow queue and returns what the engine should answer.
  function automatic deque_result_t deque_apply(input logic [MODE_W-1:0] mode,
                                                input logic [IN_DATA_W-1:0] word,
                                                input logic [IDX_W-1:0] index);
    deque_result_t res;
    int            pos;
    res = '{data: '0, status: ST_OK, length: '0};
    pos = int'(index);
    case (mode)
      MODE_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
          shadow_mem[shadow_head] = word[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      MODE_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_mem[(shadow_head + shadow_count) % CAPACITY] = word[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % CAPACITY;
          shadow_count--;
        end
      end
      MODE_POP_BACK: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      MODE_PEEK: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else res.data = OUT_DATA_W'(shadow_mem[(shadow_head + pos) % CAPACITY]);
      end
      MODE_RESIZE: begin
        if (pos > CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // Growth appends the fill word at the back; shrinking drops from the back.
          while (shadow_count < pos) begin
            shadow_mem[(shadow_head + shadow_count) % CAPACITY] = word[DATA_WIDTH-1:0];
            shadow_count++;
          end
          shadow_count = pos;
        end
      end
      MODE_CLEAR: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count = 0;
          shadow_head = 0;
        end
      end
      default: ;
    endcase
    res.length = OUT_LEN_W'(shadow_count);
    return res;
  endfunction

  // Idle cycles before the next beat. Now and then a run of beats goes with no gap.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(10, 40);
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Builds one random request. Most requests are meaningful for the current fill
  // level: peeks mostly land inside the queue and resizes mostly move by a few dozen
  // entries, so the queue wanders between empty and full. Spare modes, wild indexes
  // and jumps to the capacity edge make up the rest.
  function automatic void draw_request(input int phase, output logic [MODE_W-1:0] mode,
                                       output logic [IN_DATA_W-1:0] word,
                                       output logic [IDX_W-1:0] index);
    int pick;
    int push_weight;
    int target;
    int step;
    pick = $urandom_range(0, 99);
    word = $urandom;
    index = IDX_W'($urandom_range(0, 2047));
    case (phase)
      PH_GROW:  push_weight = 45;
      PH_DRAIN: push_weight = 15;
      default:  push_weight = 33;
    endcase
    if (pick < 2) begin
      mode = MODE_SPARE;
    end else if (pick < 5) begin
      mode = MODE_CLEAR;
    end else if (pick < 25) begin
      mode = MODE_PEEK;
      if (shadow_count > 0 && $urandom_range(0, 5) != 0)
        index = IDX_W'($urandom_range(0, shadow_count - 1));
      else if ($urandom_range(0, 1) == 0)
        index = IDX_W'(shadow_count);
    end else if (pick < 35) begin
      mode = MODE_RESIZE;
      step = $urandom_range(0, 9);
      if (step == 1) begin
        index = IDX_W'(CAPACITY - 2 + $urandom_range(0, 3));
      end else if (step != 0) begin
        step = $urandom_range(0, 48);
        case (phase)
          PH_GROW:  target = shadow_count + step;
          PH_DRAIN: target = shadow_count - step;
          default:  target = shadow_count + step - 24;
        endcase
        if (target < 0) target = 0;
        if (target > CAPACITY) target = CAPACITY;
        index = IDX_W'(target);
      end
    end else if ($urandom_range(0, 64) < push_weight) begin
      mode = ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    end else begin
      mode = ($urandom_range(0, 1) != 0) ? MODE_POP_FRONT : MODE_POP_BACK;
    end
  endfunction

  // Offers one request beat and waits until the engine takes it. The shadow queue is
  // stepped at the accepting edge. A typed row replaces the shadow answer with the
  // one written in the table, while the shadow queue still advances.
  int sender_run;

  task automatic offer_request(input logic [MODE_W-1:0] mode,
                               input logic [IN_DATA_W-1:0] word,
                               input logic [IDX_W-1:0] index,
                               input logic typed, input deque_result_t known);
    int            gap;
    deque_result_t predicted;
    gap = draw_wait(sender_run);
    // Valid drops only for a real gap, so a back-to-back beat keeps it high.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_data_in <= word;
    in_index   <= index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = deque_apply(mode, word, index);
    pending_results.push_back(typed ? known : predicted);
  endtask

  // Stimulus: reset, the directed table, then the random body, then the drain.
  initial begin
    logic [MODE_W-1:0]    mode;
    logic [IN_DATA_W-1:0] word;
    logic [IDX_W-1:0]     index;
    int                   phase;
    int                   phase_left;
    shadow_head = 0;
    shadow_count = 0;
    sender_run = 0;
    phase = PH_MIXED;
    phase_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_request(dir_rows[r].mode, dir_rows[r].data, dir_rows[r].index,
                    dir_rows[r].typed, dir_rows[r].known);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase = $urandom_range(PH_MIXED, PH_DRAIN);
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      draw_request(phase, mode, word, index);
      offer_request(mode, word, index, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Every request yields one result, so once nothing is pending the engine should
    // stay silent; a short quiet period catches any stray beat.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stall before each beat, plus one long hold that lets the
  // engine fill its output register and push back on the sender.
  initial begin
    int            wait_cycles;
    int            receiver_run;
    int            beats_taken;
    deque_result_t want;
    receiver_run = 0;
    beats_taken = 0;
    fault_count = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = draw_wait(receiver_run);
      if (beats_taken == HOLD_AT_BEAT) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result beat %0d arrived with no request pending: data %h status %0d len %0d",
                   beats_taken, out_data_out, out_status, out_length);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data || out_status !== want.status ||
            out_length !== want.length) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result beat %0d: expected data %h status %0d len %0d, got data %h status %0d len %0d",
                     beats_taken, want.data, want.status, want.length,
                     out_data_out, out_status, out_length);
        end
      end
    end
  end

  // Watchdog: any stretch without a beat on either side longer than the limit is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
